// ----- src/cbpr_pkg.sv -----
// shared types, codes and constants for the cpu bus video register port
package cbpr_pkg;

	localparam int RAM_BYTES = 2048;
	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam int MOD_SHIFT = 26;
	localparam int MOD_RECIP = ((2 ** MOD_SHIFT) + RAM_BYTES - 1) / RAM_BYTES;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_STATUS = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_CTRL   = 3'd0,
		REG_MASK   = 3'd1,
		REG_STATUS = 3'd2,
		REG_OAMA   = 3'd3,
		REG_OAMD   = 3'd4,
		REG_SCROLL = 3'd5,
		REG_ADDR   = 3'd6,
		REG_DATA   = 3'd7
	} reg_t;

	localparam logic [2:0] AREA_RAM = 3'b000;
	localparam logic [2:0] AREA_REGS = 3'b001;
	localparam logic [15:0] PALETTE_LAST_BUFFERED = 16'h3EFF;
	localparam logic [15:0] STEP_ACROSS = 16'd1;
	localparam logic [15:0] STEP_DOWN = 16'd32;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] video_address;
		logic        video_write;
		logic [7:0]  video_write_data;
		logic        video_read;
		logic [7:0]  control_value;
		logic [7:0]  mask_value;
		logic [2:0]  fine_scroll_x;
		logic [14:0] temp_video_address;
	} rsp_word_t;

	// mirrored ram index: (a mod RAM_BYTES) through a reciprocal multiply
	function automatic logic [RAM_AW-1:0] ram_index(input logic [12:0] a);
		logic [39:0] prod;
		logic [12:0] quot;
		logic [25:0] qn;
		logic [25:0] rem;
		prod = 40'(a) * 40'(MOD_RECIP);
		quot = prod[MOD_SHIFT+12:MOD_SHIFT];
		qn = 26'(quot) * 26'(RAM_BYTES);
		rem = 26'(a) - qn;
		return rem[RAM_AW-1:0];
	endfunction

endpackage

// ----- src/cbpr_req_if.sv -----
// bus access channel: one access word per handshake
interface cbpr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [7:0]  vram_data;

	modport source (output valid, command, address, write_data, vram_data, input ready);
	modport sink (input valid, command, address, write_data, vram_data, output ready);
endinterface

// ----- src/cbpr_rsp_if.sv -----
// result channel: one result word per handshake
interface cbpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [15:0] video_address;
	logic        video_write;
	logic [7:0]  video_write_data;
	logic        video_read;
	logic [7:0]  control_value;
	logic [7:0]  mask_value;
	logic [2:0]  fine_scroll_x;
	logic [14:0] temp_video_address;

	modport source (output valid, read_data, video_address, video_write, video_write_data,
		video_read, control_value, mask_value, fine_scroll_x, temp_video_address,
		input ready);
	modport sink (input valid, read_data, video_address, video_write, video_write_data,
		video_read, control_value, mask_value, fine_scroll_x, temp_video_address,
		output ready);
endinterface

// ----- src/cpu_bus_ppu_register_port.sv -----
// cpu bus port: mirrored work ram and video register file
//
//   channel | dir | word
//   req     | in  | command, address, write_data, vram_data
//   rsp     | out | read_data, video address/strobes, register views
//
// one access per clock sustained while rsp is not stalled; each result passes
// the ram read stage, then the output register
// registers update at the accepting edge; ram needs no clearing pass
// a stalled rsp holds the output register; req keeps flowing until s1 is also full
module cpu_bus_ppu_register_port (
	input logic clk,
	input logic arst_n,
	cbpr_req_if.sink req,
	cbpr_rsp_if.source rsp
);

	logic [7:0]  control_q, mask_q, status_q, buffer_q;
	logic [14:0] temp_q;
	logic [15:0] vaddr_q;
	logic [2:0]  fine_x_q;
	logic        toggle_q;

	logic [7:0]  control_n, mask_n, status_n, buffer_n;
	logic [14:0] temp_n;
	logic [15:0] vaddr_n;
	logic [2:0]  fine_x_n;
	logic        toggle_n;

	logic        accept;
	logic        adv_s1;
	logic        valid_s1, from_ram_s1;
	cbpr_pkg::rsp_word_t word_s1, word_n;
	cbpr_pkg::rsp_word_t merged_word;
	logic        valid_s2;
	cbpr_pkg::rsp_word_t word_s2;

	logic        ram_we, ram_re, from_ram_n;
	logic [cbpr_pkg::RAM_AW-1:0] ram_idx;
	logic [7:0]  ram [cbpr_pkg::RAM_BYTES];
	logic [7:0]  ram_rdata_q;

	logic [15:0] vaddr_step;
	logic [2:0]  area;
	cbpr_pkg::cmd_t cmd;
	cbpr_pkg::reg_t rsel;

	assign adv_s1 = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;
	assign accept = req.valid && req.ready;

	assign cmd = cbpr_pkg::cmd_t'(req.command);
	assign rsel = cbpr_pkg::reg_t'(req.address[2:0]);
	assign area = req.address[15:13];
	assign ram_idx = cbpr_pkg::ram_index(req.address[12:0]);
	assign vaddr_step = vaddr_q + (control_q[2] ? cbpr_pkg::STEP_DOWN : cbpr_pkg::STEP_ACROSS);

	always_comb begin
		control_n = control_q;
		mask_n = mask_q;
		status_n = status_q;
		buffer_n = buffer_q;
		temp_n = temp_q;
		vaddr_n = vaddr_q;
		fine_x_n = fine_x_q;
		toggle_n = toggle_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		from_ram_n = 1'b0;
		word_n = '0;
		unique case (cmd)
			cbpr_pkg::CMD_STATUS: begin
				status_n = req.write_data;
			end
			cbpr_pkg::CMD_WRITE: begin
				if (area == cbpr_pkg::AREA_RAM) begin
					ram_we = 1'b1;
				end else if (area == cbpr_pkg::AREA_REGS) begin
					unique case (rsel)
						cbpr_pkg::REG_CTRL: begin
							control_n = req.write_data;
							temp_n = {temp_q[14:12], req.write_data[1:0], temp_q[9:0]};
						end
						cbpr_pkg::REG_MASK: begin
							mask_n = req.write_data;
						end
						cbpr_pkg::REG_SCROLL: begin
							if (!toggle_q) begin
								temp_n = {temp_q[14:5], req.write_data[7:3]};
								fine_x_n = req.write_data[2:0];
								toggle_n = 1'b1;
							end else begin
								temp_n = {req.write_data[2:0], temp_q[11:10],
									req.write_data[7:3], temp_q[4:0]};
								toggle_n = 1'b0;
							end
						end
						cbpr_pkg::REG_ADDR: begin
							if (!toggle_q) begin
								temp_n = {1'b0, req.write_data[5:0], temp_q[7:0]};
								toggle_n = 1'b1;
							end else begin
								temp_n = {temp_q[14:8], req.write_data};
								vaddr_n = {1'b0, temp_q[14:8], req.write_data};
								toggle_n = 1'b0;
							end
						end
						cbpr_pkg::REG_DATA: begin
							word_n.video_address = vaddr_q;
							word_n.video_write = 1'b1;
							word_n.video_write_data = req.write_data;
							vaddr_n = vaddr_step;
						end
						default: begin
						end
					endcase
				end
			end
			cbpr_pkg::CMD_READ: begin
				if (area == cbpr_pkg::AREA_RAM) begin
					ram_re = 1'b1;
					from_ram_n = 1'b1;
				end else if (area == cbpr_pkg::AREA_REGS) begin
					if (rsel == cbpr_pkg::REG_STATUS) begin
						word_n.read_data = status_q;
						status_n = {1'b0, status_q[6:0]};
						toggle_n = 1'b0;
					end else if (rsel == cbpr_pkg::REG_DATA) begin
						word_n.video_address = vaddr_q;
						word_n.video_read = 1'b1;
						buffer_n = req.vram_data;
						word_n.read_data = (vaddr_q <= cbpr_pkg::PALETTE_LAST_BUFFERED) ?
							buffer_q : req.vram_data;
						vaddr_n = vaddr_step;
					end
				end
			end
			cbpr_pkg::CMD_NONE: begin
			end
			default: begin
			end
		endcase
		word_n.control_value = control_n;
		word_n.mask_value = mask_n;
		word_n.fine_scroll_x = fine_x_n;
		word_n.temp_video_address = temp_n;
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			mask_q <= '0;
			status_q <= '0;
			buffer_q <= '0;
			temp_q <= '0;
			vaddr_q <= '0;
			fine_x_q <= '0;
			toggle_q <= 1'b0;
		end else if (accept) begin
			control_q <= control_n;
			mask_q <= mask_n;
			status_q <= status_n;
			buffer_q <= buffer_n;
			temp_q <= temp_n;
			vaddr_q <= vaddr_n;
			fine_x_q <= fine_x_n;
			toggle_q <= toggle_n;
		end
	end

	// work ram, read data held until the next read
	always_ff @(posedge clk) begin
		if (accept && ram_we) begin
			ram[ram_idx] <= req.write_data;
		end
		if (accept && ram_re) begin
			ram_rdata_q <= ram[ram_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_comb begin
		merged_word = word_s1;
		if (from_ram_s1) begin
			merged_word.read_data = ram_rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= word_n;
			from_ram_s1 <= from_ram_n;
		end
		if (adv_s1 && valid_s1) begin
			word_s2 <= merged_word;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.read_data = word_s2.read_data;
	assign rsp.video_address = word_s2.video_address;
	assign rsp.video_write = word_s2.video_write;
	assign rsp.video_write_data = word_s2.video_write_data;
	assign rsp.video_read = word_s2.video_read;
	assign rsp.control_value = word_s2.control_value;
	assign rsp.mask_value = word_s2.mask_value;
	assign rsp.fine_scroll_x = word_s2.fine_scroll_x;
	assign rsp.temp_video_address = word_s2.temp_video_address;

endmodule
